### src/sawbc_pkg.sv
// Shared types and constants of the set-associative write-back cache.
`timescale 1ns / 1ps
`default_nettype none
package sawbc_pkg;

   // access commands; the unused code behaves as a data read
   localparam logic [1:0] CMD_IREAD  = 2'd0;
   localparam logic [1:0] CMD_DREAD  = 2'd1;
   localparam logic [1:0] CMD_DWRITE = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_SPLIT_MODE = 2'd0;
   localparam logic [1:0] CSR_LRU_ENABLE = 2'd1;
   localparam logic [1:0] CSR_L1_CYCLES  = 2'd2;
   localparam logic [1:0] CSR_RAM_CYCLES = 2'd3;

   // configuration reset values
   localparam logic       SPLIT_MODE_RST = 1'b1;
   localparam logic       LRU_ENABLE_RST = 1'b1;
   localparam logic [7:0] L1_CYCLES_RST  = 8'd1;
   localparam logic [7:0] RAM_CYCLES_RST = 8'd100;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_FETCH,
      ST_WBACK,
      ST_INSTALL,
      ST_READ,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] address;
      logic [31:0] write_data;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        hit;
      logic        wrote_back;
      logic        from_sibling;
      logic [9:0]  latency;
   } rsp_payload_type;

endpackage
`default_nettype wire

### src/set_assoc_write_back_cache_core.sv
// Top level: set-associative write-back L1 cache with its own backing word memory.
`timescale 1ns / 1ps
`default_nettype none
// A hit read passes lookup, a line-memory read and finish; a hit write skips the read.
// A miss first fetches the line (from the backing memory or the sibling cache), then
// writes a dirty victim back to the backing memory, then installs the line in the
// line memory.
// One access at a time: busy is high from acceptance until the result strobe.
// After reset the backing memory is cleared word by word, busy high meanwhile;
// the result strobe lasts one cycle and the receiver cannot stall it.
module set_assoc_write_back_cache_core #(
   parameter int WAYS           = 4,
   parameter int SETS           = 4,
   parameter int WORDS_PER_LINE = 8,
   parameter int MEM_WORDS      = 65536
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire sawbc_pkg::req_payload_type req_data,
   output logic                            rsp_strobe,
   output sawbc_pkg::rsp_payload_type      rsp_data,
   input  wire logic                       csr_we,
   input  wire logic [1:0]                 csr_index,
   input  wire logic [7:0]                 csr_wdata
);

   localparam int NUM_LINES  = 2 * SETS * WAYS;
   localparam int LINE_W     = $clog2(NUM_LINES);
   localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SET_W      = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int OFF_W      = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
   localparam int CNT_W      = $clog2(WORDS_PER_LINE + 1);
   localparam int LM_DEPTH   = NUM_LINES * WORDS_PER_LINE;
   localparam int LM_AW      = $clog2(LM_DEPTH);
   localparam int LINE_BYTES = 4 * WORDS_PER_LINE;
   localparam int TAG_W      = 32 - ($clog2(LINE_BYTES * SETS + 1) - 1);
   localparam int MA_W       = $clog2(MEM_WORDS);

   // ---------------------------------------------------------------- storage
   logic [31:0] line_mem [LM_DEPTH];     // words of all lines, both caches
   logic [31:0] backing_mem [MEM_WORDS]; // backing word memory
   logic [31:0] line_rdata_ff;
   logic [31:0] mem_rdata_ff;

   // per-line state in flops; reset clears valid, dirty and age at once, not the tags
   logic             line_valid_ff [NUM_LINES];
   logic             line_valid_in [NUM_LINES];
   logic             line_dirty_ff [NUM_LINES];
   logic             line_dirty_in [NUM_LINES];
   logic [TAG_W-1:0] line_tag_ff [NUM_LINES];
   logic [TAG_W-1:0] line_tag_in [NUM_LINES];
   logic [31:0]      line_age_ff [NUM_LINES];
   logic [31:0]      line_age_in [NUM_LINES];

   // fill buffer: line from memory or sibling, held until installed
   logic [31:0] fill_buf_ff [WORDS_PER_LINE];
   logic [31:0] fill_buf_in [WORDS_PER_LINE];

   // ---------------------------------------------------------------- control
   sawbc_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [OFF_W-1:0] rd_idx_ff, rd_idx_in;
   logic [MA_W-1:0]  clr_ff, clr_in;

   // access being served
   logic             is_write_ff, is_write_in;
   logic             cache_ff, cache_in;
   logic [SET_W-1:0] set_ff, set_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic [31:0]      wdata_ff, wdata_in;
   logic [MA_W-1:0]  fbase_ff, fbase_in;

   // lookup outcome
   logic             hit_ff, hit_in;
   logic [WAY_W-1:0] way_ff, way_in;
   logic             sib_hit_ff, sib_hit_in;
   logic [WAY_W-1:0] sib_way_ff, sib_way_in;
   logic             sib_dirty_ff, sib_dirty_in;
   logic             vdirty_ff, vdirty_in;
   logic [MA_W-1:0]  vbase_ff, vbase_in;

   // configuration
   logic       split_ff, lru_ff;
   logic [7:0] l1_cyc_ff, ram_cyc_ff;

   // response
   logic                       rsp_strobe_ff, rsp_strobe_in;
   sawbc_pkg::rsp_payload_type rsp_ff, rsp_in;

   // memory ports
   logic             lm_we;
   logic [LM_AW-1:0] lm_waddr, lm_raddr;
   logic [31:0]      lm_wdata;
   logic             bs_we;
   logic [MA_W-1:0]  bs_waddr, bs_raddr;
   logic [31:0]      bs_wdata;

   function automatic logic [LINE_W-1:0] line_idx(input logic c,
                                                  input logic [SET_W-1:0] s,
                                                  input logic [WAY_W-1:0] w);
      line_idx = LINE_W'((32'(c) * SETS + 32'(s)) * WAYS + 32'(w));
   endfunction

   function automatic logic [LM_AW-1:0] word_addr(input logic [LINE_W-1:0] l,
                                                  input logic [OFF_W-1:0] o);
      word_addr = LM_AW'(32'(l) * WORDS_PER_LINE + 32'(o));
   endfunction

   // base + word offset, wrapped at the memory size (base already below it)
   function automatic logic [MA_W-1:0] mem_wrap(input logic [MA_W-1:0] b,
                                                input logic [OFF_W-1:0] i);
      logic [MA_W:0] s;
      s = {1'b0, b} + (MA_W + 1)'(i);
      if (s >= (MA_W + 1)'(MEM_WORDS)) begin
         s = s - (MA_W + 1)'(MEM_WORDS);
      end
      mem_wrap = s[MA_W-1:0];
   endfunction

   assign busy       = (state_ff != sawbc_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // ---------------------------------------------------------------- lookup
   // Tag match in the selected cache and in its sibling, LRU victim choice.
   logic             hit_c, sib_c;
   logic [WAY_W-1:0] hway_c, sway_c, vway_c;
   logic [LINE_W-1:0] lc, lo;

   always_comb begin
      hit_c  = 1'b0;
      sib_c  = 1'b0;
      hway_c = '0;
      sway_c = '0;
      vway_c = '0;
      lc     = '0;
      lo     = '0;
      // descending, so the lowest matching way wins
      for (int w = WAYS - 1; w >= 0; w--) begin
         lc = line_idx(cache_ff, set_ff, WAY_W'(w));
         lo = line_idx(~cache_ff, set_ff, WAY_W'(w));
         if (line_valid_ff[lc] && line_tag_ff[lc] == tag_ff) begin
            hit_c  = 1'b1;
            hway_c = WAY_W'(w);
         end
         if (split_ff && line_valid_ff[lo] && line_tag_ff[lo] == tag_ff) begin
            sib_c  = 1'b1;
            sway_c = WAY_W'(w);
         end
      end
      // greatest age, lowest way on a tie; way 0 when LRU is off
      if (lru_ff) begin
         for (int w = 1; w < WAYS; w++) begin
            if (line_age_ff[line_idx(cache_ff, set_ff, WAY_W'(w))] >
                line_age_ff[line_idx(cache_ff, set_ff, vway_c)]) begin
               vway_c = WAY_W'(w);
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequencer
   logic [31:0]       acc_word;
   logic [31:0]       acc_lnum;
   logic [LINE_W-1:0] cur_line;
   logic [LINE_W-1:0] sib_line;
   logic [LINE_W-1:0] vic_line;
   logic [9:0]        lat_c;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      clr_in        = clr_ff;
      is_write_in   = is_write_ff;
      cache_in      = cache_ff;
      set_in        = set_ff;
      tag_in        = tag_ff;
      off_in        = off_ff;
      wdata_in      = wdata_ff;
      fbase_in      = fbase_ff;
      hit_in        = hit_ff;
      way_in        = way_ff;
      sib_hit_in    = sib_hit_ff;
      sib_way_in    = sib_way_ff;
      sib_dirty_in  = sib_dirty_ff;
      vdirty_in     = vdirty_ff;
      vbase_in      = vbase_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      line_valid_in = line_valid_ff;
      line_dirty_in = line_dirty_ff;
      line_tag_in   = line_tag_ff;
      line_age_in   = line_age_ff;
      fill_buf_in   = fill_buf_ff;
      lm_we         = 1'b0;
      lm_waddr      = '0;
      lm_wdata      = '0;
      lm_raddr      = '0;
      bs_we         = 1'b0;
      bs_waddr      = '0;
      bs_wdata      = '0;
      bs_raddr      = '0;
      acc_word      = req_data.address >> 2;
      acc_lnum      = req_data.address / LINE_BYTES;
      cur_line      = line_idx(cache_ff, set_ff, way_ff);
      sib_line      = line_idx(~cache_ff, set_ff, sib_way_ff);
      vic_line      = line_idx(cache_ff, set_ff, vway_c);
      lat_c         = 10'(l1_cyc_ff);
      if (!hit_ff && !sib_hit_ff) begin
         lat_c = lat_c + 10'(ram_cyc_ff);
      end
      if (!hit_ff && vdirty_ff) begin
         lat_c = lat_c + 10'(ram_cyc_ff);
      end

      case (state_ff)
         sawbc_pkg::ST_CLEAR: begin
            // zero the backing memory, one word a cycle
            bs_we    = 1'b1;
            bs_waddr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == MA_W'(MEM_WORDS - 1)) begin
               state_in = sawbc_pkg::ST_IDLE;
            end
         end
         sawbc_pkg::ST_IDLE: begin
            if (start) begin
               is_write_in = (req_data.cmd == sawbc_pkg::CMD_DWRITE);
               cache_in    = split_ff && (req_data.cmd != sawbc_pkg::CMD_IREAD);
               set_in      = SET_W'(acc_lnum % SETS);
               tag_in      = TAG_W'(acc_lnum / SETS);
               off_in      = OFF_W'(acc_word % WORDS_PER_LINE);
               wdata_in    = req_data.write_data;
               fbase_in    = MA_W'((acc_word - (acc_word % WORDS_PER_LINE)) % MEM_WORDS);
               state_in    = sawbc_pkg::ST_LOOKUP;
            end
         end
         sawbc_pkg::ST_LOOKUP: begin
            hit_in       = hit_c;
            way_in       = hit_c ? hway_c : vway_c;
            sib_hit_in   = sib_c;
            sib_way_in   = sway_c;
            sib_dirty_in = line_dirty_ff[line_idx(~cache_ff, set_ff, sway_c)];
            vdirty_in    = line_dirty_ff[vic_line];
            vbase_in     = MA_W'(((32'(line_tag_ff[vic_line]) * SETS + 32'(set_ff))
                                  * WORDS_PER_LINE) % MEM_WORDS);
            cnt_in       = '0;
            if (!hit_c) begin
               state_in = sawbc_pkg::ST_FETCH;
            end else if (is_write_ff) begin
               state_in = sawbc_pkg::ST_FINISH;
            end else begin
               state_in = sawbc_pkg::ST_READ;
            end
         end
         sawbc_pkg::ST_FETCH: begin
            // source line read before any write-back, so aliased lines fill old data
            if (cnt_ff < CNT_W'(WORDS_PER_LINE)) begin
               lm_raddr   = word_addr(sib_line, cnt_ff[OFF_W-1:0]);
               bs_raddr   = mem_wrap(fbase_ff, cnt_ff[OFF_W-1:0]);
               rd_pend_in = 1'b1;
               rd_idx_in  = cnt_ff[OFF_W-1:0];
               cnt_in     = cnt_ff + 1'b1;
            end
            if (rd_pend_ff) begin
               fill_buf_in[rd_idx_ff] = sib_hit_ff ? line_rdata_ff : mem_rdata_ff;
            end
            if (cnt_ff == CNT_W'(WORDS_PER_LINE)) begin
               cnt_in   = '0;
               state_in = vdirty_ff ? sawbc_pkg::ST_WBACK : sawbc_pkg::ST_INSTALL;
            end
         end
         sawbc_pkg::ST_WBACK: begin
            if (cnt_ff < CNT_W'(WORDS_PER_LINE)) begin
               lm_raddr   = word_addr(cur_line, cnt_ff[OFF_W-1:0]);
               rd_pend_in = 1'b1;
               rd_idx_in  = cnt_ff[OFF_W-1:0];
               cnt_in     = cnt_ff + 1'b1;
            end
            if (rd_pend_ff) begin
               bs_we    = 1'b1;
               bs_waddr = mem_wrap(vbase_ff, rd_idx_ff);
               bs_wdata = line_rdata_ff;
            end
            if (cnt_ff == CNT_W'(WORDS_PER_LINE)) begin
               cnt_in   = '0;
               state_in = sawbc_pkg::ST_INSTALL;
            end
         end
         sawbc_pkg::ST_INSTALL: begin
            lm_we    = 1'b1;
            lm_waddr = word_addr(cur_line, cnt_ff[OFF_W-1:0]);
            lm_wdata = (is_write_ff && cnt_ff[OFF_W-1:0] == off_ff) ?
                       wdata_ff : fill_buf_ff[cnt_ff[OFF_W-1:0]];
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(WORDS_PER_LINE - 1)) begin
               cnt_in   = '0;
               state_in = sawbc_pkg::ST_FINISH;
            end
         end
         sawbc_pkg::ST_READ: begin
            lm_raddr = word_addr(cur_line, off_ff);
            state_in = sawbc_pkg::ST_FINISH;
         end
         sawbc_pkg::ST_FINISH: begin
            if (is_write_ff) begin
               rsp_in.read_data = wdata_ff;
            end else if (hit_ff) begin
               rsp_in.read_data = line_rdata_ff;
            end else begin
               rsp_in.read_data = fill_buf_ff[off_ff];
            end
            rsp_in.hit          = hit_ff;
            rsp_in.wrote_back   = !hit_ff && vdirty_ff;
            rsp_in.from_sibling = !hit_ff && sib_hit_ff;
            rsp_in.latency      = lat_c;
            rsp_strobe_in       = 1'b1;

            if (!hit_ff) begin
               line_valid_in[cur_line] = 1'b1;
               line_tag_in[cur_line]   = tag_ff;
               line_dirty_in[cur_line] = sib_hit_ff && sib_dirty_ff;
            end
            if (lru_ff) begin
               for (int w = 0; w < WAYS; w++) begin
                  line_age_in[line_idx(cache_ff, set_ff, WAY_W'(w))] =
                     line_age_ff[line_idx(cache_ff, set_ff, WAY_W'(w))] + 32'd1;
               end
               line_age_in[cur_line] = '0;
            end
            if (is_write_ff) begin
               line_dirty_in[cur_line] = 1'b1;
               // a write drops the sibling's copy (split mode only)
               if (sib_hit_ff) begin
                  line_valid_in[sib_line] = 1'b0;
                  line_dirty_in[sib_line] = 1'b0;
               end
               if (hit_ff) begin
                  lm_we    = 1'b1;
                  lm_waddr = word_addr(cur_line, off_ff);
                  lm_wdata = wdata_ff;
               end
            end
            state_in = sawbc_pkg::ST_IDLE;
         end
         default: begin
            state_in = sawbc_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sawbc_pkg::ST_CLEAR;
         clr_ff        <= '0;
         cnt_ff        <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         split_ff      <= sawbc_pkg::SPLIT_MODE_RST;
         lru_ff        <= sawbc_pkg::LRU_ENABLE_RST;
         l1_cyc_ff     <= sawbc_pkg::L1_CYCLES_RST;
         ram_cyc_ff    <= sawbc_pkg::RAM_CYCLES_RST;
         for (int i = 0; i < NUM_LINES; i++) begin
            line_valid_ff[i] <= 1'b0;
            line_dirty_ff[i] <= 1'b0;
            line_age_ff[i]   <= '0;
         end
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         cnt_ff        <= cnt_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
         line_valid_ff <= line_valid_in;
         line_dirty_ff <= line_dirty_in;
         line_age_ff   <= line_age_in;
         if (csr_we) begin
            case (csr_index)
               sawbc_pkg::CSR_SPLIT_MODE: split_ff   <= csr_wdata[0];
               sawbc_pkg::CSR_LRU_ENABLE: lru_ff     <= csr_wdata[0];
               sawbc_pkg::CSR_L1_CYCLES:  l1_cyc_ff  <= csr_wdata;
               sawbc_pkg::CSR_RAM_CYCLES: ram_cyc_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      is_write_ff  <= is_write_in;
      cache_ff     <= cache_in;
      set_ff       <= set_in;
      tag_ff       <= tag_in;
      off_ff       <= off_in;
      wdata_ff     <= wdata_in;
      fbase_ff     <= fbase_in;
      hit_ff       <= hit_in;
      way_ff       <= way_in;
      sib_hit_ff   <= sib_hit_in;
      sib_way_ff   <= sib_way_in;
      sib_dirty_ff <= sib_dirty_in;
      vdirty_ff    <= vdirty_in;
      vbase_ff     <= vbase_in;
      rsp_ff       <= rsp_in;
      line_tag_ff  <= line_tag_in;
      fill_buf_ff  <= fill_buf_in;
   end

   // line word memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (lm_we) begin
         line_mem[lm_waddr] <= lm_wdata;
      end
      line_rdata_ff <= line_mem[lm_raddr];
   end

   // backing memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (bs_we) begin
         backing_mem[bs_waddr] <= bs_wdata;
      end
      mem_rdata_ff <= backing_mem[bs_raddr];
   end

   // ---------------------------------------------------------------- checks
   a_strobe_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == sawbc_pkg::ST_FINISH))
      else $error("result strobe without a finished access");

   a_hit_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.hit) |-> (!rsp_data.wrote_back && !rsp_data.from_sibling))
      else $error("hit reported with miss flags");

   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == sawbc_pkg::ST_LOOKUP))
      else $error("accepted transfer did not start a lookup");

   a_sibling_split: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sawbc_pkg::ST_LOOKUP && !split_ff) |=> !sib_hit_ff)
      else $error("sibling match in unified mode");

endmodule
`default_nettype wire
